>>> hw/rtl/rvdec_pkg.sv
// Types, constants and decode function for the RV64IMA/Zicsr instruction decoder.
`timescale 1ns / 1ps
`default_nettype none

package rvdec_pkg;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP32     = 7'h3B;
  localparam logic [6:0] OPC_AMO      = 7'h2F;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  // funct3 values that select a decode path.
  localparam logic [2:0] F3_ADD   = 3'd0;
  localparam logic [2:0] F3_SLL   = 3'd1;
  localparam logic [2:0] F3_WORD  = 3'd2;
  localparam logic [2:0] F3_DWORD = 3'd3;
  localparam logic [2:0] F3_PRIV  = 3'd4;
  localparam logic [2:0] F3_SRL   = 3'd5;
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_CSRRC = 3'd3;
  localparam logic [2:0] F3_CSRI  = 3'd5;

  // funct7 values.
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [5:0] SHIFT6_SRA = 6'h10;
  localparam logic [4:0] F5_LR      = 5'd2;

  // SYSTEM csr-field encodings.
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;
  localparam logic [11:0] SYS_MRET   = 12'h302;
  localparam logic [11:0] SYS_SRET   = 12'h102;
  localparam logic [11:0] SYS_WFI    = 12'h105;

  // Format codes.
  localparam logic [2:0] FMT_R       = 3'd0;
  localparam logic [2:0] FMT_I       = 3'd1;
  localparam logic [2:0] FMT_S       = 3'd2;
  localparam logic [2:0] FMT_B       = 3'd3;
  localparam logic [2:0] FMT_U       = 3'd4;
  localparam logic [2:0] FMT_J       = 3'd5;
  localparam logic [2:0] FMT_SYSTEM  = 3'd6;
  localparam logic [2:0] FMT_UNKNOWN = 3'd7;

  // Extension classes.
  localparam logic [2:0] EXT_BASE   = 3'd0;
  localparam logic [2:0] EXT_M      = 3'd1;
  localparam logic [2:0] EXT_A      = 3'd2;
  localparam logic [2:0] EXT_SYSTEM = 3'd3;
  localparam logic [2:0] EXT_ZICSR  = 3'd4;

  // Mnemonic codes that are produced outside the lookup tables.
  localparam logic [6:0] MN_ILLEGAL = 7'd0;
  localparam logic [6:0] MN_LUI     = 7'd1;
  localparam logic [6:0] MN_AUIPC   = 7'd2;
  localparam logic [6:0] MN_JAL     = 7'd3;
  localparam logic [6:0] MN_JALR    = 7'd4;
  localparam logic [6:0] MN_SLLI    = 7'd28;
  localparam logic [6:0] MN_SRLI    = 7'd29;
  localparam logic [6:0] MN_SRAI    = 7'd30;
  localparam logic [6:0] MN_SUB     = 7'd32;
  localparam logic [6:0] MN_SRA     = 7'd38;
  localparam logic [6:0] MN_ADDIW   = 7'd41;
  localparam logic [6:0] MN_SLLIW   = 7'd42;
  localparam logic [6:0] MN_SRLIW   = 7'd43;
  localparam logic [6:0] MN_SRAIW   = 7'd44;
  localparam logic [6:0] MN_ADDW    = 7'd45;
  localparam logic [6:0] MN_SUBW    = 7'd46;
  localparam logic [6:0] MN_SLLW    = 7'd47;
  localparam logic [6:0] MN_SRLW    = 7'd48;
  localparam logic [6:0] MN_SRAW    = 7'd49;
  localparam logic [6:0] MN_AMO_W   = 7'd62;
  localparam logic [6:0] MN_AMO_D   = 7'd73;
  localparam logic [6:0] MN_CSRRW   = 7'd85;
  localparam logic [6:0] MN_CSRRS   = 7'd86;
  localparam logic [6:0] MN_CSRRC   = 7'd87;
  localparam logic [6:0] MN_CSRRWI  = 7'd88;
  localparam logic [6:0] MN_ECALL   = 7'd91;
  localparam logic [6:0] MN_EBREAK  = 7'd92;
  localparam logic [6:0] MN_MRET    = 7'd93;
  localparam logic [6:0] MN_SRET    = 7'd94;
  localparam logic [6:0] MN_WFI     = 7'd95;
  localparam logic [6:0] MN_FENCE   = 7'd97;
  localparam logic [6:0] MN_FENCE_I = 7'd98;

  // Per-funct3 mnemonic tables; zero marks an unused encoding.
  localparam logic [6:0] BRANCH_CODE [8] = '{7'd5, 7'd6, 7'd0, 7'd0, 7'd7, 7'd8, 7'd9, 7'd10};
  localparam logic [6:0] LOAD_CODE   [8] = '{7'd11, 7'd12, 7'd13, 7'd14,
                                             7'd15, 7'd16, 7'd17, 7'd0};
  localparam logic [6:0] STORE_CODE  [8] = '{7'd18, 7'd19, 7'd20, 7'd21,
                                             7'd0, 7'd0, 7'd0, 7'd0};
  localparam logic [6:0] OPIMM_CODE  [8] = '{7'd22, 7'd0, 7'd23, 7'd24,
                                             7'd25, 7'd0, 7'd26, 7'd27};
  localparam logic [6:0] OP_BASE_CODE[8] = '{7'd31, 7'd33, 7'd34, 7'd35,
                                             7'd36, 7'd37, 7'd39, 7'd40};
  localparam logic [6:0] OP_M_CODE   [8] = '{7'd50, 7'd51, 7'd52, 7'd53,
                                             7'd54, 7'd55, 7'd56, 7'd57};
  localparam logic [6:0] OP32_M_CODE [8] = '{7'd58, 7'd0, 7'd0, 7'd0,
                                             7'd59, 7'd60, 7'd61, 7'd62};
  // funct5 to position within an atomic group, zero for none.
  localparam logic [3:0] AMO_CODE [32] = '{
    4'd4, 4'd3, 4'd1, 4'd2, 4'd5, 4'd0, 4'd0, 4'd0,
    4'd7, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0, 4'd0, 4'd0,
    4'd8, 4'd0, 4'd0, 4'd0, 4'd9, 4'd0, 4'd0, 4'd0,
    4'd10, 4'd0, 4'd0, 4'd0, 4'd11, 4'd0, 4'd0, 4'd0
  };

  typedef struct packed {
    logic               is_illegal;
    logic [6:0]         mnemonic_code;
    logic [2:0]         format_code;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic [2:0]         minor_op;
    logic [6:0]         major_func;
    logic signed [31:0] immediate_value;
    logic               acquire_bit;
    logic               release_bit;
    logic [2:0]         extension_class;
  } rvdec_result_t;

  function automatic rvdec_result_t rvdec_decode(input logic [31:0] w);
    rvdec_result_t res;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  f5;
    logic [11:0] csr;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm;
    logic [6:0]  code;
    logic [2:0]  fmt;
    logic [2:0]  ext;
    logic        aq;
    logic        rl;

    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    rs1   = w[19:15];
    rs2   = w[24:20];
    f5    = w[31:27];
    csr   = w[31:20];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    imm   = '0;
    code  = MN_ILLEGAL;
    fmt   = FMT_UNKNOWN;
    ext   = EXT_BASE;
    aq    = 1'b0;
    rl    = 1'b0;

    unique case (opc)
      OPC_LUI: begin
        code = MN_LUI;
        fmt  = FMT_U;
        imm  = {w[31:12], 12'h000};
      end
      OPC_AUIPC: begin
        code = MN_AUIPC;
        fmt  = FMT_U;
        imm  = {w[31:12], 12'h000};
      end
      OPC_JAL: begin
        code = MN_JAL;
        fmt  = FMT_J;
        imm  = imm_j;
      end
      OPC_JALR: begin
        fmt = FMT_I;
        imm = imm_i;
        if (f3 == F3_ADD) code = MN_JALR;
      end
      OPC_BRANCH: begin
        fmt  = FMT_B;
        imm  = imm_b;
        code = BRANCH_CODE[f3];
      end
      OPC_LOAD: begin
        fmt  = FMT_I;
        imm  = imm_i;
        code = LOAD_CODE[f3];
      end
      OPC_STORE: begin
        fmt  = FMT_S;
        imm  = imm_s;
        code = STORE_CODE[f3];
      end
      OPC_OP_IMM: begin
        fmt = FMT_I;
        imm = imm_i;
        if (f3 == F3_SLL) begin
          if (w[31:26] == 6'h00) begin
            code = MN_SLLI;
            imm  = {26'h0, w[25:20]};
          end
        end else if (f3 == F3_SRL) begin
          if (w[31:26] == 6'h00 || w[31:26] == SHIFT6_SRA) begin
            code = (w[31:26] == SHIFT6_SRA) ? MN_SRAI : MN_SRLI;
            imm  = {26'h0, w[25:20]};
          end
        end else begin
          code = OPIMM_CODE[f3];
        end
      end
      OPC_OP: begin
        fmt = FMT_R;
        if (f7 == F7_BASE) begin
          code = OP_BASE_CODE[f3];
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          code = MN_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SRL) begin
          code = MN_SRA;
        end else if (f7 == F7_MULDIV) begin
          code = OP_M_CODE[f3];
          ext  = EXT_M;
        end
      end
      OPC_OP_IMM32: begin
        fmt = FMT_I;
        if (f3 == F3_ADD) begin
          imm  = imm_i;
          code = MN_ADDIW;
        end else if (f3 == F3_SLL && f7 == F7_BASE) begin
          imm  = {27'h0, rs2};
          code = MN_SLLIW;
        end else if (f3 == F3_SRL && (f7 == F7_BASE || f7 == F7_ALT)) begin
          imm  = {27'h0, rs2};
          code = (f7 == F7_ALT) ? MN_SRAIW : MN_SRLIW;
        end
      end
      OPC_OP32: begin
        fmt = FMT_R;
        if (f7 == F7_BASE) begin
          if (f3 == F3_ADD) code = MN_ADDW;
          else if (f3 == F3_SLL) code = MN_SLLW;
          else if (f3 == F3_SRL) code = MN_SRLW;
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) code = MN_SUBW;
          else if (f3 == F3_SRL) code = MN_SRAW;
        end else if (f7 == F7_MULDIV) begin
          code = OP32_M_CODE[f3];
          if (code != MN_ILLEGAL) ext = EXT_M;
        end
      end
      OPC_AMO: begin
        if (f3 == F3_WORD || f3 == F3_DWORD) begin
          fmt = FMT_R;
          aq  = w[26];
          rl  = w[25];
          // A load-reserved with a nonzero rs2 is not an encoding.
          if (f5 != F5_LR || rs2 == 5'd0) begin
            ext = EXT_A;
            if (AMO_CODE[f5] != 4'd0) begin
              code = ((f3 == F3_DWORD) ? MN_AMO_D : MN_AMO_W) + {3'b000, AMO_CODE[f5]};
            end
          end
        end
      end
      OPC_MISC_MEM: begin
        fmt = FMT_SYSTEM;
        if (f3 == F3_ADD) begin
          code = MN_FENCE;
          imm  = {20'h0, csr};
        end else if (f3 == F3_SLL) begin
          code = MN_FENCE_I;
          imm  = {20'h0, csr};
        end
      end
      OPC_SYSTEM: begin
        imm = {20'h0, csr};
        if (f3 == F3_ADD) begin
          fmt = FMT_SYSTEM;
          // Privileged words are told apart by the csr field alone.
          if (csr == SYS_ECALL) code = MN_ECALL;
          else if (csr == SYS_EBREAK) code = MN_EBREAK;
          else if (csr == SYS_MRET) code = MN_MRET;
          else if (csr == SYS_SRET) code = MN_SRET;
          else if (csr == SYS_WFI) code = MN_WFI;
          if (code != MN_ILLEGAL) ext = EXT_SYSTEM;
        end else if (f3 != F3_PRIV) begin
          fmt = FMT_I;
          ext = EXT_ZICSR;
          if (f3 == F3_CSRRW) begin
            code = MN_CSRRW;
          end else if (f3 == F3_CSRRS) begin
            if (rs1 != 5'd0) code = MN_CSRRS;
          end else if (f3 == F3_CSRRC) begin
            if (rs1 != 5'd0) code = MN_CSRRC;
          end else begin
            code = MN_CSRRWI + {4'h0, f3 - F3_CSRI};
          end
        end
      end
      default: begin
        code = MN_ILLEGAL;
      end
    endcase

    if (code == MN_ILLEGAL) fmt = FMT_UNKNOWN;

    res.is_illegal      = (code == MN_ILLEGAL);
    res.mnemonic_code   = code;
    res.format_code     = fmt;
    res.dest_reg        = w[11:7];
    res.src1_reg        = rs1;
    res.src2_reg        = rs2;
    res.minor_op        = f3;
    res.major_func      = f7;
    res.immediate_value = imm;
    res.acquire_bit     = aq;
    res.release_bit     = rl;
    res.extension_class = ext;
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rvdec_if.sv
// Valid/ready channel interfaces for instruction words and decode results.
`timescale 1ns / 1ps
`default_nettype none

interface rvdec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface rvdec_out_if import rvdec_pkg::*;;
  logic          valid;
  logic          ready;
  rvdec_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rv64_instruction_decoder.sv
// RV64IMA/Zicsr instruction decoder: word register, decode logic, result register.
//
// The block takes one 32-bit instruction word on in_chan and returns one decode result
// on out_chan for every word, in order. Both channels use valid/ready, and a word
// moves on a rising edge of clk at which valid and ready are both high.
//
// A word accepted at a clock edge is held in the input register, decoded by purely
// combinational logic, and captured in the result register once that register is
// empty or being emptied; the result is then presented on out_chan. The block
// sustains one word per clock cycle; the only limit is the result register, which
// must be emptied for the pipe to advance.
//
// When the receiver holds out_chan.ready low, the result stays stable in the result
// register and one more word may still be taken into the input register; only
// when both registers are full does in_chan.ready fall. When the receiver takes
// the result, both stages advance in the same cycle, so no bubble is inserted.
//
// A synchronous active-low reset on rst_n empties both stages; no result is
// shown until a new word arrives. There are no configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module rv64_instruction_decoder import rvdec_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  rvdec_in_if.sink      in_chan,
  rvdec_out_if.source   out_chan
);

  // Input stage: the raw word waiting to be decoded.
  logic          word_valid_r;
  logic          word_valid_nxt;
  logic [31:0]   word_r;

  // Output stage: the decoded result waiting for the receiver.
  logic          out_valid_r;
  logic          out_valid_nxt;
  rvdec_result_t result_r;

  logic          stage_advance;
  logic          in_ready;
  logic          in_take;
  rvdec_result_t result_nxt;

  // The result register can load whenever it is empty or being emptied.
  assign stage_advance = !out_valid_r || out_chan.ready;
  // The input register can load whenever it is empty or its word moves on this cycle.
  assign in_ready      = !word_valid_r || stage_advance;
  assign in_take       = in_chan.valid && in_ready;

  assign result_nxt    = rvdec_decode(word_r);

  always_comb begin
    word_valid_nxt = word_valid_r;
    out_valid_nxt  = out_valid_r;
    if (in_ready) begin
      word_valid_nxt = in_chan.valid;
    end
    if (stage_advance) begin
      out_valid_nxt = word_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      word_valid_r <= word_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers load only with a live word and need no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      word_r <= in_chan.instruction_word;
    end
    if (stage_advance && word_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign in_chan.ready   = in_ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.result = result_r;

endmodule

`default_nettype wire

>>> verif/rv64_instruction_decoder_tb.sv
// Self-checking testbench for the RV64IMA/Zicsr instruction decoder.
`timescale 1ns / 1ps

module rv64_instruction_decoder_tb;
  import rvdec_pkg::*;

  // The run is stopped as a failure if it is still going after this many cycles. The
  // limit leaves a wide margin over the slowest correct run, about 2000 words, each
  // with the longest send gap and the longest receive stall.
  localparam int CYCLE_LIMIT = 250000;
  localparam int RANDOM_WORDS = 1950;

  // Mnemonic numbering of the decoder, in its listing order. The expected results are
  // built from these names so that the tables below can be read against the ISA.
  typedef enum logic [6:0] {
    MNE_ILLEGAL = 7'd0,
    MNE_LUI, MNE_AUIPC, MNE_JAL, MNE_JALR,
    MNE_BEQ, MNE_BNE, MNE_BLT, MNE_BGE, MNE_BLTU, MNE_BGEU,
    MNE_LB, MNE_LH, MNE_LW, MNE_LD, MNE_LBU, MNE_LHU, MNE_LWU,
    MNE_SB, MNE_SH, MNE_SW, MNE_SD,
    MNE_ADDI, MNE_SLTI, MNE_SLTIU, MNE_XORI, MNE_ORI, MNE_ANDI,
    MNE_SLLI, MNE_SRLI, MNE_SRAI,
    MNE_ADD, MNE_SUB, MNE_SLL, MNE_SLT, MNE_SLTU, MNE_XOR, MNE_SRL, MNE_SRA,
    MNE_OR, MNE_AND,
    MNE_ADDIW, MNE_SLLIW, MNE_SRLIW, MNE_SRAIW,
    MNE_ADDW, MNE_SUBW, MNE_SLLW, MNE_SRLW, MNE_SRAW,
    MNE_MUL, MNE_MULH, MNE_MULHSU, MNE_MULHU, MNE_DIV, MNE_DIVU, MNE_REM, MNE_REMU,
    MNE_MULW, MNE_DIVW, MNE_DIVUW, MNE_REMW, MNE_REMUW,
    MNE_LR_W, MNE_SC_W, MNE_AMOSWAP_W, MNE_AMOADD_W, MNE_AMOXOR_W, MNE_AMOAND_W,
    MNE_AMOOR_W, MNE_AMOMIN_W, MNE_AMOMAX_W, MNE_AMOMINU_W, MNE_AMOMAXU_W,
    MNE_LR_D, MNE_SC_D, MNE_AMOSWAP_D, MNE_AMOADD_D, MNE_AMOXOR_D, MNE_AMOAND_D,
    MNE_AMOOR_D, MNE_AMOMIN_D, MNE_AMOMAX_D, MNE_AMOMINU_D, MNE_AMOMAXU_D,
    MNE_CSRRW, MNE_CSRRS, MNE_CSRRC, MNE_CSRRWI, MNE_CSRRSI, MNE_CSRRCI,
    MNE_ECALL, MNE_EBREAK, MNE_MRET, MNE_SRET, MNE_WFI, MNE_SFENCE_VMA,
    MNE_FENCE, MNE_FENCE_I
  } mnemonic_e;

  // Atomic funct5 encodings.
  localparam logic [4:0] AF5_AMOADD  = 5'd0;
  localparam logic [4:0] AF5_AMOSWAP = 5'd1;
  localparam logic [4:0] AF5_LR      = 5'd2;
  localparam logic [4:0] AF5_SC      = 5'd3;
  localparam logic [4:0] AF5_AMOXOR  = 5'd4;
  localparam logic [4:0] AF5_UNUSED  = 5'd5;
  localparam logic [4:0] AF5_AMOOR   = 5'd8;
  localparam logic [4:0] AF5_AMOAND  = 5'd12;
  localparam logic [4:0] AF5_AMOMIN  = 5'd16;
  localparam logic [4:0] AF5_AMOMAX  = 5'd20;
  localparam logic [4:0] AF5_AMOMINU = 5'd24;
  localparam logic [4:0] AF5_AMOMAXU = 5'd28;

  // A few funct3 and funct7 values used to build directed words.
  localparam logic [2:0] F3_LWU      = 3'd6;
  localparam logic [2:0] F3_LOAD_BAD = 3'd7;
  localparam logic [2:0] F3_BGEU     = 3'd7;
  localparam logic [2:0] F3_REMU     = 3'd7;
  localparam logic [2:0] F3_CSRRCI   = 3'd7;
  localparam logic [6:0] F7_SFENCE   = 7'h09;

  // Mnemonics selected by funct3 for each opcode that uses a plain lookup.
  localparam logic [6:0] BRANCH_OPS [8] = '{MNE_BEQ, MNE_BNE, MNE_ILLEGAL, MNE_ILLEGAL,
                                            MNE_BLT, MNE_BGE, MNE_BLTU, MNE_BGEU};
  localparam logic [6:0] LOAD_OPS [8] = '{MNE_LB, MNE_LH, MNE_LW, MNE_LD,
                                          MNE_LBU, MNE_LHU, MNE_LWU, MNE_ILLEGAL};
  localparam logic [6:0] STORE_OPS [8] = '{MNE_SB, MNE_SH, MNE_SW, MNE_SD,
                                           MNE_ILLEGAL, MNE_ILLEGAL, MNE_ILLEGAL,
                                           MNE_ILLEGAL};
  localparam logic [6:0] IMM_ALU_OPS [8] = '{MNE_ADDI, MNE_SLLI, MNE_SLTI, MNE_SLTIU,
                                             MNE_XORI, MNE_SRLI, MNE_ORI, MNE_ANDI};
  localparam logic [6:0] REG_ALU_OPS [8] = '{MNE_ADD, MNE_SLL, MNE_SLT, MNE_SLTU,
                                             MNE_XOR, MNE_SRL, MNE_OR, MNE_AND};
  localparam logic [6:0] MULDIV_OPS [8] = '{MNE_MUL, MNE_MULH, MNE_MULHSU, MNE_MULHU,
                                            MNE_DIV, MNE_DIVU, MNE_REM, MNE_REMU};
  localparam logic [6:0] WORD_ALU_OPS [8] = '{MNE_ADDW, MNE_SLLW, MNE_ILLEGAL,
                                              MNE_ILLEGAL, MNE_ILLEGAL, MNE_SRLW,
                                              MNE_ILLEGAL, MNE_ILLEGAL};
  localparam logic [6:0] WORD_MULDIV_OPS [8] = '{MNE_MULW, MNE_ILLEGAL, MNE_ILLEGAL,
                                                 MNE_ILLEGAL, MNE_DIVW, MNE_DIVUW,
                                                 MNE_REMW, MNE_REMUW};
  localparam logic [6:0] CSR_OPS [8] = '{MNE_ILLEGAL, MNE_CSRRW, MNE_CSRRS, MNE_CSRRC,
                                         MNE_ILLEGAL, MNE_CSRRWI, MNE_CSRRSI,
                                         MNE_CSRRCI};

  // Pools for the random word generator.
  localparam logic [4:0] AMO_FUNCT5 [11] = '{AF5_LR, AF5_SC, AF5_AMOSWAP, AF5_AMOADD,
                                             AF5_AMOXOR, AF5_AMOAND, AF5_AMOOR,
                                             AF5_AMOMIN, AF5_AMOMAX, AF5_AMOMINU,
                                             AF5_AMOMAXU};
  localparam logic [6:0] KNOWN_OPCODES [14] = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR,
                                                OPC_BRANCH, OPC_LOAD, OPC_STORE,
                                                OPC_OP_IMM, OPC_OP, OPC_OP_IMM32,
                                                OPC_OP32, OPC_AMO, OPC_MISC_MEM,
                                                OPC_SYSTEM};
  localparam logic [11:0] PRIV_CSRS [5] = '{SYS_ECALL, SYS_EBREAK, SYS_MRET, SYS_SRET,
                                            SYS_WFI};

  // One accepted word together with the decode that it must produce.
  typedef struct {
    logic [31:0]   word;
    rvdec_result_t want;
  } pending_decode_t;

  // The receiver picks among these stall patterns at random so that back-pressure lands
  // on every phase of the two-stage pipe, including long runs with none at all.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_CHOPPY,
    RX_STARVED
  } rx_pattern_e;

  logic clk;
  logic rst_n;

  rvdec_in_if  in_bus ();
  rvdec_out_if out_bus ();

  rv64_instruction_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  pending_decode_t pending_decodes[$];
  int              mismatch_count;
  int              cycle_count;
  int              burst_left;
  rx_pattern_e     rx_pattern;
  int              rx_pattern_left;
  int              rx_phase;

  always #6 clk = ~clk;

  // Decode of one word, written independently of the design from the ISA tables above.
  function automatic rvdec_result_t predict_decode(input logic [31:0] w);
    rvdec_result_t r;
    logic [6:0]    opc;
    logic [2:0]    f3;
    logic [6:0]    f7;
    logic [4:0]    f5;
    logic [4:0]    rs1;
    logic [4:0]    rs2;
    logic [11:0]   csr;
    logic [31:0]   imm_i;
    logic [31:0]   imm;
    logic [6:0]    code;
    logic [6:0]    amo_word_op;
    logic [2:0]    fmt;
    logic [2:0]    ext;
    logic          aq;
    logic          rl;

    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    f5    = w[31:27];
    rs1   = w[19:15];
    rs2   = w[24:20];
    csr   = w[31:20];
    imm_i = {{21{w[31]}}, w[30:20]};
    imm   = '0;
    code  = MNE_ILLEGAL;
    fmt   = FMT_UNKNOWN;
    ext   = EXT_BASE;
    aq    = 1'b0;
    rl    = 1'b0;

    case (opc)
      OPC_LUI, OPC_AUIPC: begin
        code = (opc == OPC_LUI) ? MNE_LUI : MNE_AUIPC;
        fmt  = FMT_U;
        imm  = {w[31:12], 12'h000};
      end
      OPC_JAL: begin
        code = MNE_JAL;
        fmt  = FMT_J;
        imm  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        fmt = FMT_I;
        imm = imm_i;
        if (f3 == F3_ADD) code = MNE_JALR;
      end
      OPC_BRANCH: begin
        fmt  = FMT_B;
        imm  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        code = BRANCH_OPS[f3];
      end
      OPC_LOAD: begin
        fmt  = FMT_I;
        imm  = imm_i;
        code = LOAD_OPS[f3];
      end
      OPC_STORE: begin
        fmt  = FMT_S;
        imm  = {{21{w[31]}}, w[30:25], w[11:7]};
        code = STORE_OPS[f3];
      end
      OPC_OP_IMM: begin
        fmt = FMT_I;
        imm = imm_i;
        // Shifts take a six-bit amount and need the bits above it to be a known
        // shift kind; otherwise the word is illegal and keeps the I immediate.
        if (f3 == F3_SLL || f3 == F3_SRL) begin
          if (w[31:26] == 6'h00 || (f3 == F3_SRL && w[31:26] == SHIFT6_SRA)) begin
            code = (w[31:26] == SHIFT6_SRA) ? MNE_SRAI : IMM_ALU_OPS[f3];
            imm  = {26'h0, w[25:20]};
          end
        end else begin
          code = IMM_ALU_OPS[f3];
        end
      end
      OPC_OP: begin
        fmt = FMT_R;
        if (f7 == F7_BASE) begin
          code = REG_ALU_OPS[f3];
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) code = MNE_SUB;
          else if (f3 == F3_SRL) code = MNE_SRA;
        end else if (f7 == F7_MULDIV) begin
          code = MULDIV_OPS[f3];
          ext  = EXT_M;
        end
      end
      OPC_OP_IMM32: begin
        fmt = FMT_I;
        if (f3 == F3_ADD) begin
          code = MNE_ADDIW;
          imm  = imm_i;
        end else if (f3 == F3_SLL && f7 == F7_BASE) begin
          code = MNE_SLLIW;
          imm  = {27'h0, rs2};
        end else if (f3 == F3_SRL && (f7 == F7_BASE || f7 == F7_ALT)) begin
          code = (f7 == F7_ALT) ? MNE_SRAIW : MNE_SRLIW;
          imm  = {27'h0, rs2};
        end
      end
      OPC_OP32: begin
        fmt = FMT_R;
        if (f7 == F7_BASE) begin
          code = WORD_ALU_OPS[f3];
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) code = MNE_SUBW;
          else if (f3 == F3_SRL) code = MNE_SRAW;
        end else if (f7 == F7_MULDIV) begin
          code = WORD_MULDIV_OPS[f3];
          if (code != MNE_ILLEGAL) ext = EXT_M;
        end
      end
      OPC_AMO: begin
        // The ordering bits are reported for any word or doubleword atomic, and the
        // class is A even when funct5 names no operation. Only a load-reserved with
        // a nonzero rs2 falls back to the base class.
        if (f3 == F3_WORD || f3 == F3_DWORD) begin
          fmt = FMT_R;
          aq  = w[26];
          rl  = w[25];
          if (f5 != AF5_LR || rs2 == 5'd0) begin
            ext = EXT_A;
            case (f5)
              AF5_LR:      amo_word_op = MNE_LR_W;
              AF5_SC:      amo_word_op = MNE_SC_W;
              AF5_AMOSWAP: amo_word_op = MNE_AMOSWAP_W;
              AF5_AMOADD:  amo_word_op = MNE_AMOADD_W;
              AF5_AMOXOR:  amo_word_op = MNE_AMOXOR_W;
              AF5_AMOAND:  amo_word_op = MNE_AMOAND_W;
              AF5_AMOOR:   amo_word_op = MNE_AMOOR_W;
              AF5_AMOMIN:  amo_word_op = MNE_AMOMIN_W;
              AF5_AMOMAX:  amo_word_op = MNE_AMOMAX_W;
              AF5_AMOMINU: amo_word_op = MNE_AMOMINU_W;
              AF5_AMOMAXU: amo_word_op = MNE_AMOMAXU_W;
              default:     amo_word_op = MNE_ILLEGAL;
            endcase
            if (amo_word_op != MNE_ILLEGAL && f3 == F3_DWORD) begin
              code = amo_word_op + (MNE_LR_D - MNE_LR_W);
            end else begin
              code = amo_word_op;
            end
          end
        end
      end
      OPC_MISC_MEM: begin
        fmt = FMT_SYSTEM;
        if (f3 == F3_ADD || f3 == F3_SLL) begin
          code = (f3 == F3_ADD) ? MNE_FENCE : MNE_FENCE_I;
          imm  = {20'h0, csr};
        end
      end
      OPC_SYSTEM: begin
        imm = {20'h0, csr};
        if (f3 == F3_ADD) begin
          // Privileged words are recognized by the csr field alone; rd and rs1 are
          // not looked at.
          fmt = FMT_SYSTEM;
          case (csr)
            SYS_ECALL:  code = MNE_ECALL;
            SYS_EBREAK: code = MNE_EBREAK;
            SYS_MRET:   code = MNE_MRET;
            SYS_SRET:   code = MNE_SRET;
            SYS_WFI:    code = MNE_WFI;
            default:    code = MNE_ILLEGAL;
          endcase
          if (code != MNE_ILLEGAL) ext = EXT_SYSTEM;
        end else if (f3 != F3_PRIV) begin
          // Set and clear forms with rs1 of zero are rejected but keep the class.
          fmt  = FMT_I;
          ext  = EXT_ZICSR;
          code = CSR_OPS[f3];
          if ((f3 == F3_CSRRS || f3 == F3_CSRRC) && rs1 == 5'd0) code = MNE_ILLEGAL;
        end
      end
      default: begin
        code = MNE_ILLEGAL;
      end
    endcase

    if (code == MNE_ILLEGAL) fmt = FMT_UNKNOWN;

    r.is_illegal      = (code == MNE_ILLEGAL);
    r.mnemonic_code   = code;
    r.format_code     = fmt;
    r.dest_reg        = w[11:7];
    r.src1_reg        = rs1;
    r.src2_reg        = rs2;
    r.minor_op        = f3;
    r.major_func      = f7;
    r.immediate_value = imm;
    r.acquire_bit     = aq;
    r.release_bit     = rl;
    r.extension_class = ext;
    return r;
  endfunction

  // Packs an R-shaped word; S and B words use the funct7 and rd slots for immediates.
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm12, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm12, rs1, f3, rd, opc};
  endfunction

  // A random word that is a valid instruction of a randomly chosen group; all fields
  // that the encoding leaves free keep random content.
  function automatic logic [31:0] random_valid_word();
    logic [31:0] w;
    int          pick;

    w    = $urandom();
    pick = $urandom_range(0, 2);
    case ($urandom_range(0, 13))
      0: w[6:0] = ($urandom_range(0, 1) == 0) ? OPC_LUI : OPC_AUIPC;
      1: w[6:0] = OPC_JAL;
      2: begin
        w[6:0]   = OPC_JALR;
        w[14:12] = F3_ADD;
      end
      3: begin
        // Branches skip the two unused funct3 values in the middle.
        w[6:0]   = OPC_BRANCH;
        pick     = $urandom_range(0, 5);
        w[14:12] = (pick < 2) ? 3'(pick) : 3'(pick + 2);
      end
      4: begin
        w[6:0]   = OPC_LOAD;
        w[14:12] = 3'($urandom_range(0, 6));
      end
      5: begin
        w[6:0]   = OPC_STORE;
        w[14:12] = 3'($urandom_range(0, 3));
      end
      6: begin
        w[6:0] = OPC_OP_IMM;
        if (w[14:12] == F3_SLL) w[31:26] = 6'h00;
        if (w[14:12] == F3_SRL) w[31:26] = ($urandom_range(0, 1) == 0) ? 6'h00 : SHIFT6_SRA;
      end
      7: begin
        w[6:0] = OPC_OP;
        if (pick == 0) begin
          w[31:25] = F7_BASE;
        end else if (pick == 1) begin
          w[31:25] = F7_MULDIV;
        end else begin
          w[31:25] = F7_ALT;
          w[14:12] = ($urandom_range(0, 1) == 0) ? F3_ADD : F3_SRL;
        end
      end
      8: begin
        w[6:0] = OPC_OP_IMM32;
        if (pick == 0) begin
          w[14:12] = F3_ADD;
        end else if (pick == 1) begin
          w[14:12] = F3_SLL;
          w[31:25] = F7_BASE;
        end else begin
          w[14:12] = F3_SRL;
          w[31:25] = ($urandom_range(0, 1) == 0) ? F7_BASE : F7_ALT;
        end
      end
      9: begin
        w[6:0] = OPC_OP32;
        if (pick == 0) begin
          w[31:25] = F7_BASE;
          pick     = $urandom_range(0, 2);
          w[14:12] = (pick == 0) ? F3_ADD : (pick == 1) ? F3_SLL : F3_SRL;
        end else if (pick == 1) begin
          w[31:25] = F7_ALT;
          w[14:12] = ($urandom_range(0, 1) == 0) ? F3_ADD : F3_SRL;
        end else begin
          w[31:25] = F7_MULDIV;
          pick     = $urandom_range(0, 4);
          w[14:12] = (pick == 0) ? F3_ADD : 3'(pick + 3);
        end
      end
      10: begin
        w[6:0]   = OPC_AMO;
        w[14:12] = ($urandom_range(0, 1) == 0) ? F3_WORD : F3_DWORD;
        w[31:27] = AMO_FUNCT5[$urandom_range(0, 10)];
        if (w[31:27] == AF5_LR) w[24:20] = 5'd0;
      end
      11: begin
        w[6:0]   = OPC_MISC_MEM;
        w[14:12] = ($urandom_range(0, 1) == 0) ? F3_ADD : F3_SLL;
      end
      12: begin
        w[6:0]   = OPC_SYSTEM;
        w[14:12] = F3_ADD;
        w[31:20] = PRIV_CSRS[$urandom_range(0, 4)];
      end
      default: begin
        // CSR forms: funct3 one to three and five to seven.
        w[6:0]   = OPC_SYSTEM;
        pick     = $urandom_range(0, 5);
        w[14:12] = (pick < 3) ? 3'(pick + 1) : 3'(pick + 2);
      end
    endcase
    return w;
  endfunction

  // Offers one word and holds it until the decoder takes it. Between words the
  // sender keeps valid high within a burst and after a burst may drop it for a random gap.
  task automatic send_word(input logic [31:0] word);
    int gap;

    in_bus.valid            <= 1'b1;
    in_bus.instruction_word <= word;
    do begin
      @(posedge clk);
    end while (in_bus.ready !== 1'b1);
    pending_decodes.push_back('{word: word, want: predict_decode(word)});
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stops offering words until every outstanding decode has been checked.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (pending_decodes.size() != 0) @(negedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] word,
                               input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      $error("word %h: %s expected %0h, got %0h", word, name, want, seen);
      mismatch_count++;
    end
  endtask

  task automatic check_decode(input pending_decode_t exp, input rvdec_result_t got);
    compare_field("is_illegal", exp.word, exp.want.is_illegal, got.is_illegal);
    compare_field("mnemonic_code", exp.word, exp.want.mnemonic_code, got.mnemonic_code);
    compare_field("format_code", exp.word, exp.want.format_code, got.format_code);
    compare_field("dest_reg", exp.word, exp.want.dest_reg, got.dest_reg);
    compare_field("src1_reg", exp.word, exp.want.src1_reg, got.src1_reg);
    compare_field("src2_reg", exp.word, exp.want.src2_reg, got.src2_reg);
    compare_field("minor_op", exp.word, exp.want.minor_op, got.minor_op);
    compare_field("major_func", exp.word, exp.want.major_func, got.major_func);
    compare_field("immediate_value", exp.word, exp.want.immediate_value,
                  got.immediate_value);
    compare_field("acquire_bit", exp.word, exp.want.acquire_bit, got.acquire_bit);
    compare_field("release_bit", exp.word, exp.want.release_bit, got.release_bit);
    compare_field("extension_class", exp.word, exp.want.extension_class,
                  got.extension_class);
  endtask

  // Every result the receiver takes is matched against the oldest outstanding word.
  // Outputs are sampled at the rising edge, before the design's registers update.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_decodes.size() == 0) begin
        $error("decode result %h arrived with no word outstanding", out_bus.result);
        mismatch_count++;
      end else begin
        check_decode(pending_decodes.pop_front(), out_bus.result);
      end
    end
  end

  // Receiver back-pressure. Each pattern runs for a random stretch of cycles; the
  // starved pattern gives the longest stalls.
  always @(negedge clk) begin
    if (rx_pattern_left == 0) begin
      rx_pattern      = rx_pattern_e'($urandom_range(0, 3));
      rx_pattern_left = $urandom_range(40, 300);
    end
    rx_pattern_left--;
    rx_phase++;
    case (rx_pattern)
      RX_OPEN:   out_bus.ready <= 1'b1;
      RX_RANDOM: out_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_CHOPPY: out_bus.ready <= (rx_phase % 3 != 0);
      default:   out_bus.ready <= (rx_phase % 13 == 12);
    endcase
  end

  // Hard stop in case the design stops accepting words or stops producing results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("rv64_instruction_decoder_tb NOT OK");
      $finish;
    end
  end

  // Immediate extremes of the U, J, B and S formats and the all-zero and all-one words.
  task automatic test_field_extremes();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word({20'hFFFFF, 5'd31, OPC_LUI});
    send_word({1'b1, 19'h00000, 5'd1, OPC_JAL});
    send_word(enc_r(7'h7F, 5'd31, 5'd31, F3_BGEU, 5'd31, OPC_BRANCH));
    send_word(enc_r(7'h40, 5'd0, 5'd0, F3_DWORD, 5'd0, OPC_STORE));
  endtask

  // One word from each of the less obvious decode paths; the random part covers
  // every mnemonic that the decoder produces many times over.
  task automatic test_operation_groups();
    send_word(enc_i({SHIFT6_SRA, 6'h3F}, 5'd5, F3_SRL, 5'd6, OPC_OP_IMM));
    send_word(enc_r(F7_ALT, 5'd2, 5'd3, F3_ADD, 5'd4, OPC_OP));
    send_word(enc_r(F7_MULDIV, 5'd17, 5'd18, F3_REMU, 5'd19, OPC_OP32));
    send_word(enc_r({AF5_AMOMAXU, 2'b11}, 5'd9, 5'd10, F3_DWORD, 5'd11, OPC_AMO));
    send_word(enc_i(12'h8FF, 5'd0, F3_ADD, 5'd0, OPC_MISC_MEM));
    send_word(enc_i(12'h000, 5'd0, F3_SLL, 5'd0, OPC_MISC_MEM));
    send_word(enc_i(12'hFFF, 5'd31, F3_CSRRCI, 5'd1, OPC_SYSTEM));
    send_word(enc_r(F7_ALT, 5'd31, 5'd1, F3_SRL, 5'd2, OPC_OP_IMM32));
    send_word(enc_i(12'h7FF, 5'd12, F3_LWU, 5'd13, OPC_LOAD));
  endtask

  // Words that the decoder rejects or treats in its own particular way.
  task automatic test_special_words();
    // Set and clear with rs1 of zero are rejected.
    send_word(enc_i(12'h300, 5'd0, F3_CSRRS, 5'd5, OPC_SYSTEM));
    send_word(enc_i(12'h341, 5'd0, F3_CSRRC, 5'd6, OPC_SYSTEM));
    // Privileged words are matched on the csr field even with nonzero rd and rs1.
    send_word(enc_i(SYS_EBREAK, 5'd7, F3_ADD, 5'd9, OPC_SYSTEM));
    send_word(enc_i(SYS_ECALL, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM));
    send_word(enc_i(SYS_MRET, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM));
    send_word(enc_i(SYS_WFI, 5'd3, F3_ADD, 5'd0, OPC_SYSTEM));
    // Address-space fence has a mnemonic but is never decoded.
    send_word(enc_r(F7_SFENCE, 5'd1, 5'd2, F3_ADD, 5'd0, OPC_SYSTEM));
    send_word(enc_i(12'h123, 5'd4, F3_PRIV, 5'd8, OPC_SYSTEM));
    // Load-reserved with a nonzero rs2, and an atomic with no operation.
    send_word(enc_r({AF5_LR, 2'b10}, 5'd3, 5'd4, F3_WORD, 5'd5, OPC_AMO));
    send_word(enc_r({AF5_UNUSED, 2'b01}, 5'd3, 5'd4, F3_WORD, 5'd5, OPC_AMO));
    // Immediate shift with bits above the amount that name no shift.
    send_word(enc_i({6'h01, 6'h05}, 5'd1, F3_SLL, 5'd1, OPC_OP_IMM));
    send_word(enc_i(12'h000, 5'd1, F3_LOAD_BAD, 5'd1, OPC_LOAD));
  endtask

  // Mostly valid instructions with random content, the rest known opcodes with
  // random fields (which reach the rejected combinations) and fully random words.
  task automatic test_random_mix(input int count);
    int roll;

    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_word(random_valid_word());
      end else if (roll < 85) begin
        send_word({25'($urandom_range(0, 33554431)), KNOWN_OPCODES[$urandom_range(0, 13)]});
      end else begin
        send_word($urandom());
      end
    end
  endtask

  // The sender goes quiet until the pipe has fully drained, then resumes.
  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++) send_word(random_valid_word());
    wait_for_results();
    burst_left = 0;
  endtask

  initial begin
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    in_bus.valid            = 1'b0;
    in_bus.instruction_word = '0;
    out_bus.ready           = 1'b0;
    mismatch_count          = 0;
    cycle_count             = 0;
    burst_left              = 0;
    rx_pattern              = RX_OPEN;
    rx_pattern_left         = 0;
    rx_phase                = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_operation_groups();
    test_special_words();
    test_random_mix(RANDOM_WORDS / 2);
    test_drain_pause();
    test_random_mix(RANDOM_WORDS - RANDOM_WORDS / 2);

    // Let the last results come out, then keep waiting on rising edges so that a
    // stray extra result would still be seen by the checker.
    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rv64_instruction_decoder_tb OK");
    end else begin
      $display("rv64_instruction_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
